/* rtl/css_pkg.sv */
package css_pkg;

    localparam int CSS_CAPACITY  = 64;
    localparam int CSS_KEY_WIDTH = 32;
    localparam int CSS_DATA_W    = 32;

    // control from the sequencer to the compare-swap unit
    typedef struct packed {
        logic clr_moved;
        logic load;
        logic step;
        logic bwd;
    } swap_ctl_t;

endpackage

/* rtl/css_key_ram.sv */
module css_key_ram #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32,
    parameter int IW        = $clog2(CAPACITY)
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [IW-1:0]        waddr,
    input  logic [KEY_WIDTH-1:0] wdata,
    input  logic [IW-1:0]        raddr,
    output logic [KEY_WIDTH-1:0] rdata
);

    logic [KEY_WIDTH-1:0] mem [CAPACITY];
    logic [KEY_WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/css_swap_unit.sv */
module css_swap_unit #(
    parameter int KEY_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  css_pkg::swap_ctl_t   ctl,
    input  logic [KEY_WIDTH-1:0] rd_key,
    output logic [KEY_WIDTH-1:0] wr_key,
    output logic [KEY_WIDTH-1:0] carry_key,
    output logic                 moved
);
    import css_pkg::*;

    logic [KEY_WIDTH-1:0] carry_reg;
    logic [KEY_WIDTH-1:0] carry_next;
    logic                 moved_reg;
    logic                 moved_next;
    logic                 swap;

    // forward: carried key sits left of the neighbor; backward: right of it
    always_comb begin
        if (ctl.bwd) begin
            swap = $signed(rd_key) > $signed(carry_reg);
        end else begin
            swap = $signed(carry_reg) > $signed(rd_key);
        end
        wr_key     = swap ? rd_key : carry_reg;
        carry_next = carry_reg;
        if (ctl.load) begin
            carry_next = rd_key;
        end else if (ctl.step && !swap) begin
            carry_next = rd_key;
        end
        moved_next = moved_reg;
        if (ctl.clr_moved) begin
            moved_next = 1'b0;
        end else if (ctl.step && swap) begin
            moved_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        carry_reg <= carry_next;
        if (!aresetn) begin
            moved_reg <= 1'b0;
        end else begin
            moved_reg <= moved_next;
        end
    end

    assign carry_key = carry_reg;
    assign moved     = moved_reg;

endmodule

/* rtl/css_ctrl.sv */
module css_ctrl #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32,
    parameter int IW        = $clog2(CAPACITY),
    parameter int CW        = $clog2(CAPACITY + 1)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [css_pkg::CSS_DATA_W-1:0]    s_key,
    input  logic                              s_final,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [css_pkg::CSS_DATA_W-1:0]    m_key,
    output logic                              m_last,
    output logic                              m_ovf,
    output logic                              mem_we,
    output logic [IW-1:0]                     mem_waddr,
    output logic [KEY_WIDTH-1:0]              mem_wdata,
    output logic [IW-1:0]                     mem_raddr,
    input  logic [KEY_WIDTH-1:0]              mem_rdata,
    output css_pkg::swap_ctl_t                swap_ctl,
    input  logic [KEY_WIDTH-1:0]              swap_wr_key,
    input  logic [KEY_WIDTH-1:0]              swap_carry,
    input  logic                              swap_moved
);
    import css_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD,
        S_RD0,
        S_RD1,
        S_STEP,
        S_FLUSH,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_HOLD
    } state_t;

    state_t               state_reg;
    logic [CW-1:0]        count_reg;
    logic                 ovf_reg;
    logic [IW-1:0]        left_reg;
    logic [IW-1:0]        right_reg;
    logic [IW-1:0]        cur_reg;
    logic                 bwd_reg;
    logic [IW-1:0]        k_reg;
    logic [KEY_WIDTH-1:0] out_key_reg;
    logic                 out_last_reg;
    logic                 out_valid_reg;

    logic [63:0]          in_wide;
    logic [63:0]          out_wide;
    logic [KEY_WIDTH-1:0] in_key;
    logic                 room;
    logic                 accept;
    logic [CW-1:0]        n_fin;
    logic                 step_last;

    assign in_wide  = {32'd0, s_key};
    assign in_key   = in_wide[KEY_WIDTH-1:0];
    assign out_wide = 64'(out_key_reg);
    assign m_key    = out_wide[CSS_DATA_W-1:0];
    assign m_last   = out_last_reg;
    assign m_ovf    = ovf_reg;
    assign m_tvalid = out_valid_reg;

    assign room     = count_reg < CW'(CAPACITY);
    assign s_tready = (state_reg == S_LOAD);
    assign accept   = s_tvalid && s_tready;
    assign n_fin    = room ? count_reg + CW'(1) : count_reg;
    assign step_last = bwd_reg ? (cur_reg - IW'(1) == left_reg)
                               : (cur_reg + IW'(1) == right_reg);

    always_comb begin
        mem_we             = 1'b0;
        mem_waddr          = cur_reg;
        mem_wdata          = swap_carry;
        mem_raddr          = k_reg;
        swap_ctl.clr_moved = 1'b0;
        swap_ctl.load      = 1'b0;
        swap_ctl.step      = 1'b0;
        swap_ctl.bwd       = bwd_reg;
        unique case (state_reg)
            S_LOAD: begin
                mem_we             = accept && room;
                mem_waddr          = count_reg[IW-1:0];
                mem_wdata          = in_key;
                swap_ctl.clr_moved = accept;
            end
            S_RD0: begin
                mem_raddr = bwd_reg ? right_reg : left_reg;
            end
            S_RD1: begin
                mem_raddr     = bwd_reg ? cur_reg - IW'(1) : cur_reg + IW'(1);
                swap_ctl.load = 1'b1;
            end
            S_STEP: begin
                // prefetch the neighbor of the next step
                mem_raddr     = bwd_reg ? cur_reg - IW'(2) : cur_reg + IW'(2);
                mem_we        = 1'b1;
                mem_wdata     = swap_wr_key;
                swap_ctl.step = 1'b1;
            end
            S_FLUSH: begin
                mem_we             = 1'b1;
                mem_wdata          = swap_carry;
                swap_ctl.clr_moved = bwd_reg && swap_moved;
            end
            S_OUT_RD, S_OUT_LD, S_OUT_HOLD: begin
                mem_raddr = k_reg;
            end
            default: begin
                mem_raddr = k_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_LOAD: begin
                    if (accept) begin
                        count_reg <= n_fin;
                        if (!room) begin
                            ovf_reg <= 1'b1;
                        end
                        if (s_final) begin
                            left_reg  <= '0;
                            right_reg <= IW'(n_fin - CW'(1));
                            bwd_reg   <= 1'b0;
                            k_reg     <= '0;
                            state_reg <= (n_fin > CW'(1)) ? S_RD0 : S_OUT_RD;
                        end
                    end
                end
                S_RD0: begin
                    cur_reg   <= bwd_reg ? right_reg : left_reg;
                    state_reg <= S_RD1;
                end
                S_RD1: begin
                    state_reg <= S_STEP;
                end
                S_STEP: begin
                    cur_reg <= bwd_reg ? cur_reg - IW'(1) : cur_reg + IW'(1);
                    if (step_last) begin
                        state_reg <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    if (!bwd_reg) begin
                        right_reg <= right_reg - IW'(1);
                        if (right_reg - IW'(1) > left_reg) begin
                            bwd_reg   <= 1'b1;
                            state_reg <= S_RD0;
                        end else begin
                            state_reg <= S_OUT_RD;
                        end
                    end else begin
                        // a round without a swap ends the sort early
                        left_reg <= left_reg + IW'(1);
                        if (swap_moved && (left_reg + IW'(1) < right_reg)) begin
                            bwd_reg   <= 1'b0;
                            state_reg <= S_RD0;
                        end else begin
                            state_reg <= S_OUT_RD;
                        end
                    end
                end
                S_OUT_RD: begin
                    state_reg <= S_OUT_LD;
                end
                S_OUT_LD: begin
                    out_key_reg   <= mem_rdata;
                    out_last_reg  <= (CW'(k_reg) + CW'(1) == count_reg);
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OUT_HOLD;
                end
                S_OUT_HOLD: begin
                    if (m_tready) begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg) begin
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= S_LOAD;
                        end else begin
                            k_reg     <= k_reg + IW'(1);
                            state_reg <= S_OUT_RD;
                        end
                    end
                end
                default: begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

endmodule

/* rtl/cocktail_shaker_sorter.sv */
// Collects signed keys, one per request, until a request with tlast set, then sorts
// them ascending with alternating forward and backward bubble passes and streams them
// out, tlast on the final key and tuser set on every key of a set in which keys past
// CAPACITY were dropped. Keys can be taken back to back while loading. The sort runs through one
// compare-swap unit and a key memory with one read and one write port, one neighbor
// comparison per cycle during a pass; a round without a swap ends the sort early. Each sorted
// key is read from memory, loaded into the output register and held until m_tready takes
// it; the next key is not read before then. No request is taken from the input side
// between the last key of a set and the last result of that set.
module cocktail_shaker_sorter #(
    parameter int CAPACITY  = css_pkg::CSS_CAPACITY,
    parameter int KEY_WIDTH = css_pkg::CSS_KEY_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [css_pkg::CSS_DATA_W-1:0] s_tdata,   // [31:0] key_in
    input  logic                           s_tlast,   // is_final
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [css_pkg::CSS_DATA_W-1:0] m_tdata,   // [31:0] key_out
    output logic                           m_tlast,   // end_of_run
    output logic                           m_tuser    // [0] overflowed
);
    import css_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic                 mem_we;
    logic [IW-1:0]        mem_waddr;
    logic [KEY_WIDTH-1:0] mem_wdata;
    logic [IW-1:0]        mem_raddr;
    logic [KEY_WIDTH-1:0] mem_rdata;
    swap_ctl_t            swap_ctl;
    logic [KEY_WIDTH-1:0] swap_wr_key;
    logic [KEY_WIDTH-1:0] swap_carry;
    logic                 swap_moved;

    css_key_ram #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH),
        .IW        (IW)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    css_swap_unit #(
        .KEY_WIDTH (KEY_WIDTH)
    ) u_swap (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (swap_ctl),
        .rd_key    (mem_rdata),
        .wr_key    (swap_wr_key),
        .carry_key (swap_carry),
        .moved     (swap_moved)
    );

    css_ctrl #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH),
        .IW        (IW),
        .CW        (CW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_key       (s_tdata),
        .s_final     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_key       (m_tdata),
        .m_last      (m_tlast),
        .m_ovf       (m_tuser),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata),
        .swap_ctl    (swap_ctl),
        .swap_wr_key (swap_wr_key),
        .swap_carry  (swap_carry),
        .swap_moved  (swap_moved)
    );

endmodule
